FILE: src/mbhr_pkg.sv
// ----------------------------------------------------------------------------
// mbhr_pkg
// Shared types, constants and helpers for the holding-register slave.
// ----------------------------------------------------------------------------
package mbhr_pkg;

    // request payload
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } req_t;

    // result payload
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } rsp_t;

    // configuration register indexes
    localparam logic [4:0] CFG_SLAVE_ADDRESS = 5'd0;
    localparam logic [4:0] CFG_ACTIVE_REGS   = 5'd1;
    localparam logic [4:0] CFG_WP_MASK       = 5'd2;

    // function codes and exception codes
    localparam logic [7:0] FN_READ   = 8'd3;
    localparam logic [7:0] FN_WRITE1 = 8'd6;
    localparam logic [7:0] FN_WRITEN = 8'd16;
    localparam logic [7:0] EX_ADDR   = 8'h02;
    localparam logic [7:0] EX_VALUE  = 8'h03;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,    // read buffer header bytes
        ST_CRC,      // crc over received frame
        ST_CHECK,    // crc compare and decode
        ST_PROT,     // protect scan for write-several
        ST_WRITE,    // write-several data moves
        ST_TX        // emit response bytes
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_frame;
        logic hdr_load;
        logic crc_init;
        logic crc_step;
        logic wr_step;
        logic tx_start;
        logic tx_step;
    } cmd_t;

    // one crc byte step, reflected poly 0xA001
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: src/modbus_holding_register_slave_top.sv
// ----------------------------------------------------------------------------
// modbus_holding_register_slave_top
// Modbus RTU slave serving a table of holding registers.
// ----------------------------------------------------------------------------
// usage:
//   request channel: raise start with req (one received byte plus an
//   end_of_frame flag) while busy is low; the byte is taken that edge.
//   ordinary bytes never raise busy.
//   on the end_of_frame byte busy rises and the frame is handled: header
//   fetch, a crc walk over the buffer and a check; a write-several
//   frame then takes a protect scan, a data walk (skipped if the scan
//   fails) and a second check; last comes the reply, one byte per cycle.
//   result channel: each reply byte shows for one cycle with done high;
//   last_byte marks the final crc byte. the receiver cannot stall.
//   dropped frames and broadcasts end quietly with no result.
//   configuration: cfg_we, cfg_index, cfg_data write a register at once.
//   reset clears the register table, counters and state; config returns
//   to address 1, sixteen active registers and no write protection.
// ----------------------------------------------------------------------------
module modbus_holding_register_slave_top #(
    parameter int MAX_REGISTERS = 16,
    parameter int RX_DEPTH      = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mbhr_pkg::req_t    req,
    output logic              busy,
    output logic              done,
    output mbhr_pkg::rsp_t    rsp,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    logic [7:0]  slave_address_reg;
    logic [4:0]  active_registers_reg;
    logic [15:0] write_protect_mask_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg      <= 8'd1;
            active_registers_reg   <= 5'd16;
            write_protect_mask_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbhr_pkg::CFG_SLAVE_ADDRESS: slave_address_reg      <= cfg_data[7:0];
                mbhr_pkg::CFG_ACTIVE_REGS:   active_registers_reg   <= cfg_data[4:0];
                mbhr_pkg::CFG_WP_MASK:       write_protect_mask_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    mbhr_pkg::cmd_t cmd;
    logic rx_valid, frame_end, hdr_done, crc_done, chk_drop, chk_scan, chk_reply;
    logic prot_done, prot_fail, wr_done, tx_done;
    logic in_prot, in_check;

    assign rx_valid = start && !busy;

    mbhr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_end (frame_end),
        .hdr_done  (hdr_done),
        .crc_done  (crc_done),
        .chk_drop  (chk_drop),
        .chk_scan  (chk_scan),
        .chk_reply (chk_reply),
        .prot_done (prot_done),
        .prot_fail (prot_fail),
        .wr_done   (wr_done),
        .tx_done   (tx_done),
        .busy      (busy),
        .in_check  (in_check),
        .in_prot   (in_prot),
        .cmd       (cmd)
    );

    mbhr_datapath #(
        .MAX_REGISTERS (MAX_REGISTERS),
        .RX_DEPTH      (RX_DEPTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .rx_valid           (rx_valid),
        .rx                 (req),
        .slave_address      (slave_address_reg),
        .active_registers   (active_registers_reg),
        .write_protect_mask (write_protect_mask_reg),
        .cmd                (cmd),
        .in_prot            (in_prot),
        .in_check           (in_check),
        .frame_end          (frame_end),
        .hdr_done           (hdr_done),
        .crc_done           (crc_done),
        .chk_drop           (chk_drop),
        .chk_scan           (chk_scan),
        .chk_reply          (chk_reply),
        .prot_done          (prot_done),
        .prot_fail          (prot_fail),
        .wr_done            (wr_done),
        .tx_done            (tx_done),
        .tx_valid           (done),
        .tx                 (rsp)
    );

endmodule

FILE: src/mbhr_ctrl.sv
// ----------------------------------------------------------------------------
// mbhr_ctrl
// Frame-end sequencer: steps the datapath through header fetch, crc, checks, write-mask scan, data write and reply.
// ----------------------------------------------------------------------------
module mbhr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_end,
    input  logic               hdr_done,
    input  logic               crc_done,
    input  logic               chk_drop,
    input  logic               chk_scan,
    input  logic               chk_reply,
    input  logic               prot_done,
    input  logic               prot_fail,
    input  logic               wr_done,
    input  logic               tx_done,
    output logic               busy,
    output logic               in_check,
    output logic               in_prot,
    output mbhr_pkg::cmd_t     cmd
);

    mbhr_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbhr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // phase status for the datapath
    assign in_check = (state_reg == mbhr_pkg::ST_CHECK);
    assign in_prot  = (state_reg == mbhr_pkg::ST_PROT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != mbhr_pkg::ST_IDLE);
        case (state_reg)
            mbhr_pkg::ST_IDLE:
            begin
                if (frame_end)
                begin
                    state_next = mbhr_pkg::ST_FETCH;
                end
            end
            mbhr_pkg::ST_FETCH:
            begin
                cmd.hdr_load = 1'b1;
                if (hdr_done)
                begin
                    cmd.crc_init = 1'b1;
                    state_next   = mbhr_pkg::ST_CRC;
                end
            end
            mbhr_pkg::ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (crc_done)
                begin
                    state_next = mbhr_pkg::ST_CHECK;
                end
            end
            mbhr_pkg::ST_CHECK:
            begin
                if (chk_drop)
                begin
                    cmd.clear_frame = 1'b1;
                    state_next      = mbhr_pkg::ST_IDLE;
                end
                else if (chk_scan)
                begin
                    state_next = mbhr_pkg::ST_PROT;
                end
                else if (chk_reply)
                begin
                    cmd.tx_start = 1'b1;
                    state_next   = mbhr_pkg::ST_TX;
                end
                else
                begin
                    cmd.clear_frame = 1'b1;
                    state_next      = mbhr_pkg::ST_IDLE;
                end
            end
            mbhr_pkg::ST_PROT:
            begin
                if (prot_fail || prot_done)
                begin
                    state_next = prot_fail ? mbhr_pkg::ST_CHECK : mbhr_pkg::ST_WRITE;
                end
            end
            mbhr_pkg::ST_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (wr_done)
                begin
                    state_next = mbhr_pkg::ST_CHECK;
                end
            end
            mbhr_pkg::ST_TX:
            begin
                cmd.tx_step = 1'b1;
                if (tx_done)
                begin
                    cmd.clear_frame = 1'b1;
                    state_next      = mbhr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbhr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/mbhr_datapath.sv
// ----------------------------------------------------------------------------
// mbhr_datapath
// Receive buffer, register table, crc unit, request checks and reply bytes.
// ----------------------------------------------------------------------------
module mbhr_datapath #(
    parameter int MAX_REGISTERS = 16,
    parameter int RX_DEPTH      = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    input  mbhr_pkg::req_t      rx,
    input  logic [7:0]          slave_address,
    input  logic [4:0]          active_registers,
    input  logic [15:0]         write_protect_mask,
    input  mbhr_pkg::cmd_t      cmd,
    input  logic                in_prot,
    input  logic                in_check,
    output logic                frame_end,
    output logic                hdr_done,
    output logic                crc_done,
    output logic                chk_drop,
    output logic                chk_scan,
    output logic                chk_reply,
    output logic                prot_done,
    output logic                prot_fail,
    output logic                wr_done,
    output logic                tx_done,
    output logic                tx_valid,
    output mbhr_pkg::rsp_t      tx
);

    localparam int AW = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int RW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

    // receive buffer memory
    logic [7:0]    rxmem [RX_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rx_count_reg;
    logic          rx_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_count_reg < CW'(RX_DEPTH))
        begin
            rxmem[rx_count_reg[AW-1:0]] <= rx.rx_byte;
        end
        rd_data_reg <= rxmem[rd_addr];
    end

    // fill count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            rx_ovf_reg   <= 1'b0;
        end
        else if (cmd.clear_frame)
        begin
            rx_count_reg <= '0;
            rx_ovf_reg   <= 1'b0;
        end
        else if (rx_valid)
        begin
            if (rx_count_reg < CW'(RX_DEPTH))
            begin
                rx_count_reg <= rx_count_reg + 1'b1;
            end
            else
            begin
                rx_ovf_reg <= 1'b1;
            end
        end
    end

    assign frame_end = rx_valid && rx.end_of_frame;

    // sequencing pointer for header, crc and data walks
    logic [CW:0]   ptr_reg;
    logic [CW:0]   ptr_d1_reg;
    logic          ptr_vld_reg;
    logic [7:0]    hdr_reg [7];
    logic [15:0]   crc_reg;
    logic [7:0]    crc_lo_reg, crc_hi_reg;
    logic [7:0]    wr_hi_reg;
    logic [RW-1:0] wr_idx_reg;

    // header fetch reads bytes 0..6, crc walk reads 0..n-1
    always_comb
    begin
        rd_addr = ptr_reg[AW-1:0];
    end

    assign hdr_done = cmd.hdr_load && ptr_vld_reg && (ptr_d1_reg == (CW+1)'(6));
    assign crc_done = cmd.crc_step && ptr_vld_reg
                      && (ptr_d1_reg + 1'b1 == {1'b0, rx_count_reg});

    logic [CW:0] wr_last;
    assign wr_last = (CW+1)'(7) + (CW+1)'({hdr_reg[6]} & 8'hFE) - 1'b1;

    // walk pointer and header capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            ptr_d1_reg  <= '0;
            ptr_vld_reg <= 1'b0;
        end
        else if (cmd.hdr_load && !hdr_done)
        begin
            ptr_reg     <= ptr_reg + 1'b1;
            ptr_d1_reg  <= ptr_reg;
            ptr_vld_reg <= 1'b1;
        end
        else if (cmd.crc_init)
        begin
            ptr_reg     <= '0;
            ptr_vld_reg <= 1'b0;
        end
        else if (cmd.crc_step || cmd.wr_step)
        begin
            ptr_reg     <= ptr_reg + 1'b1;
            ptr_d1_reg  <= ptr_reg;
            ptr_vld_reg <= 1'b1;
        end
        else
        begin
            // data walk starts at byte 7, header fetch at byte 0
            ptr_reg     <= in_prot ? (CW+1)'(7) : '0;
            ptr_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_load && ptr_vld_reg && ptr_d1_reg < (CW+1)'(7))
        begin
            hdr_reg[ptr_d1_reg[2:0]] <= rd_data_reg;
        end
        if (cmd.crc_init)
        begin
            crc_reg <= 16'hFFFF;
        end
        else if (cmd.crc_step && ptr_vld_reg)
        begin
            // last two bytes are the received crc, low first
            if (ptr_d1_reg + 2'd2 == {1'b0, rx_count_reg})
            begin
                crc_lo_reg <= rd_data_reg;
            end
            else if (ptr_d1_reg + 1'b1 == {1'b0, rx_count_reg})
            begin
                crc_hi_reg <= rd_data_reg;
            end
            else
            begin
                crc_reg <= mbhr_pkg::crc_byte(crc_reg, rd_data_reg);
            end
        end
    end

    // request decode
    logic [7:0]  func;
    logic        bcast;
    logic [15:0] first, count;
    logic [4:0]  eff;
    logic [16:0] span;
    logic        len_ok, crc_ok, fn_ok;
    assign func  = hdr_reg[1];
    assign bcast = (hdr_reg[0] == 8'h00);
    assign first = {hdr_reg[2], hdr_reg[3]};
    assign count = {hdr_reg[4], hdr_reg[5]};
    assign eff   = (active_registers > 5'(MAX_REGISTERS)) ? 5'(MAX_REGISTERS) : active_registers;
    assign span  = {1'b0, first} + {1'b0, count};
    assign fn_ok = (func == mbhr_pkg::FN_READ) || (func == mbhr_pkg::FN_WRITE1)
                   || (func == mbhr_pkg::FN_WRITEN);
    always_comb
    begin
        if (func == mbhr_pkg::FN_WRITEN)
        begin
            len_ok = ({1'b0, rx_count_reg} >= (CW+1)'(7))
                     && (16'(rx_count_reg) == 16'd9 + 16'(hdr_reg[6]));
        end
        else
        begin
            len_ok = ({1'b0, rx_count_reg} == (CW+1)'(8));
        end
    end
    assign crc_ok = (crc_reg == {crc_hi_reg, crc_lo_reg});

    logic range_bad;
    assign range_bad = (count > {11'd0, eff}) || (first >= {11'd0, eff})
                       || (span > {12'd0, eff});

    // check outcome flags, scanned_reg and written_reg mark return after scan or write
    logic scanned_reg, written_reg, prot_bad_reg;
    logic        is_exc;
    logic [7:0]  exc_code;
    logic        do_w6;
    always_comb
    begin
        is_exc   = 1'b0;
        exc_code = mbhr_pkg::EX_ADDR;
        do_w6    = 1'b0;
        case (func)
            mbhr_pkg::FN_READ:
            begin
                if (count == 16'd0)
                begin
                    is_exc   = 1'b1;
                    exc_code = mbhr_pkg::EX_VALUE;
                end
                else if (range_bad)
                begin
                    is_exc = 1'b1;
                end
            end
            mbhr_pkg::FN_WRITE1:
            begin
                if (first >= {11'd0, eff} || (first < 16'd16 && write_protect_mask[first[3:0]]))
                begin
                    is_exc = 1'b1;
                end
                else
                begin
                    do_w6 = 1'b1;
                end
            end
            default:
            begin
                if (hdr_reg[6] == 8'd0 || count == 16'd0 || count != {9'd0, hdr_reg[6][7:1]})
                begin
                    is_exc   = 1'b1;
                    exc_code = mbhr_pkg::EX_VALUE;
                end
                else if (range_bad || prot_bad_reg)
                begin
                    is_exc = 1'b1;
                end
            end
        endcase
    end

    logic valid_frame;
    assign valid_frame = !rx_ovf_reg && ({1'b0, rx_count_reg} >= (CW+1)'(2)) && fn_ok
                         && len_ok && crc_ok;
    // broadcasts end quietly, an error-free write-several one only after its data is written
    assign chk_drop  = in_check && (!valid_frame
                       || (bcast && (is_exc || func != mbhr_pkg::FN_WRITEN || written_reg)));
    assign chk_scan  = in_check && valid_frame && !chk_drop && func == mbhr_pkg::FN_WRITEN
                       && !is_exc && !scanned_reg;
    assign chk_reply = in_check && valid_frame && !chk_drop
                       && (is_exc || func != mbhr_pkg::FN_WRITEN || written_reg);

    // protect scan, one register a cycle
    logic [4:0] scan_reg;
    logic [4:0] scan_end;
    assign scan_end  = 5'(first[4:0] + count[4:0]);
    assign prot_fail = in_prot && write_protect_mask[scan_reg[3:0]];
    assign prot_done = in_prot && (scan_reg + 1'b1 == scan_end);

    // register table
    logic [15:0] regs_reg [MAX_REGISTERS];
    logic        wr_lo;
    assign wr_lo   = ptr_vld_reg && ptr_d1_reg[0] == 1'b0;
    assign wr_done = cmd.wr_step && ptr_vld_reg && ptr_d1_reg == wr_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_REGISTERS; i++)
            begin
                regs_reg[i] <= '0;
            end
            scanned_reg  <= 1'b0;
            written_reg  <= 1'b0;
            prot_bad_reg <= 1'b0;
            scan_reg     <= '0;
            wr_idx_reg   <= '0;
            wr_hi_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_frame)
            begin
                scanned_reg  <= 1'b0;
                written_reg  <= 1'b0;
                prot_bad_reg <= 1'b0;
            end
            if (in_check)
            begin
                scan_reg   <= first[4:0];
                wr_idx_reg <= RW'(first);
                if (do_w6 && valid_frame && !written_reg)
                begin
                    regs_reg[RW'(first)] <= count;
                    if (!cmd.clear_frame)
                    begin
                        written_reg <= 1'b1;
                    end
                end
            end
            if (in_prot)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (prot_fail)
                begin
                    prot_bad_reg <= 1'b1;
                    scanned_reg  <= 1'b1;
                end
                else if (prot_done)
                begin
                    scanned_reg <= 1'b1;
                end
            end
            if (cmd.wr_step && ptr_vld_reg)
            begin
                if (!wr_lo)
                begin
                    wr_hi_reg <= rd_data_reg;
                end
                else
                begin
                    regs_reg[wr_idx_reg] <= {wr_hi_reg, rd_data_reg};
                    wr_idx_reg           <= RW'(wr_idx_reg + 1'b1);
                end
                if (wr_done)
                begin
                    written_reg <= 1'b1;
                end
            end
        end
    end

    // response generator
    logic [5:0]  tx_idx_reg, tx_len_reg;
    logic        tx_on_reg, tx_exc_reg;
    logic [7:0]  tx_code_reg;
    logic [15:0] tx_crc_reg;
    logic [7:0]  body;
    logic [4:0]  ridx;
    logic [15:0] rval;
    logic [5:0]  k;
    assign k    = tx_idx_reg - 6'd3;
    assign ridx = 5'(first[4:0] + {1'b0, k[5:1]});
    assign rval = regs_reg[RW'(ridx)];
    always_comb
    begin
        body = 8'h00;
        if (tx_idx_reg == 6'd0)
        begin
            body = slave_address;
        end
        else if (tx_exc_reg)
        begin
            body = (tx_idx_reg == 6'd1) ? (func | 8'h80) : tx_code_reg;
        end
        else if (func == mbhr_pkg::FN_READ)
        begin
            if (tx_idx_reg == 6'd1)
            begin
                body = func;
            end
            else if (tx_idx_reg == 6'd2)
            begin
                body = {count[6:0], 1'b0};
            end
            else
            begin
                body = k[0] ? rval[7:0] : rval[15:8];
            end
        end
        else if (tx_idx_reg < 6'd7)
        begin
            body = hdr_reg[tx_idx_reg[2:0]];
        end
    end

    logic [7:0] tx_byte_c;
    always_comb
    begin
        if (tx_idx_reg == tx_len_reg)
        begin
            tx_byte_c = tx_crc_reg[7:0];
        end
        else if (tx_idx_reg == tx_len_reg + 1'b1)
        begin
            tx_byte_c = tx_crc_reg[15:8];
        end
        else
        begin
            tx_byte_c = body;
        end
    end
    assign tx_done = tx_on_reg && (tx_idx_reg == tx_len_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_on_reg   <= 1'b0;
            tx_idx_reg  <= '0;
            tx_len_reg  <= '0;
            tx_exc_reg  <= 1'b0;
            tx_code_reg <= '0;
            tx_crc_reg  <= '0;
            tx_valid    <= 1'b0;
            tx          <= '0;
        end
        else
        begin
            tx_valid <= cmd.tx_step && tx_on_reg && !cmd.tx_start;
            if (cmd.tx_start)
            begin
                tx_on_reg   <= 1'b1;
                tx_idx_reg  <= '0;
                tx_exc_reg  <= is_exc;
                tx_code_reg <= exc_code;
                tx_crc_reg  <= 16'hFFFF;
                if (is_exc)
                begin
                    tx_len_reg <= 6'd3;
                end
                else if (func == mbhr_pkg::FN_READ)
                begin
                    tx_len_reg <= 6'd3 + {count[4:0], 1'b0};
                end
                else
                begin
                    tx_len_reg <= 6'd6;
                end
            end
            else if (cmd.tx_step && tx_on_reg)
            begin
                tx.tx_byte   <= tx_byte_c;
                tx.last_byte <= tx_done;
                tx_idx_reg   <= tx_idx_reg + 1'b1;
                if (tx_idx_reg < tx_len_reg)
                begin
                    tx_crc_reg <= mbhr_pkg::crc_byte(tx_crc_reg, body);
                end
                if (tx_done)
                begin
                    tx_on_reg <= 1'b0;
                end
            end
        end
    end

endmodule
